FILE: sv/ubx_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// ubx_frame_receiver assertion macros
// Shared assertion forms for the frame receiver checker.
// ----------------------------------------------------------------------------
`ifndef UBX_FRAME_RECEIVER_ASSERT_SVH
`define UBX_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UBX_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ubx: same-cycle check failed");

// Next-cycle implication, sampled through reset.
`define UBX_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ubx: next-cycle check failed");

`endif

FILE: sv/ubx_pkg.sv
// ----------------------------------------------------------------------------
// ubx_pkg
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ubx_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int POS_W     = 17;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_SYNC_FIRST    = 3'd0;
    localparam t_cfg_idx REG_SYNC_SECOND   = 3'd1;
    localparam t_cfg_idx REG_WANTED_CLASS  = 3'd2;
    localparam t_cfg_idx REG_WANTED_ID     = 3'd3;
    localparam t_cfg_idx REG_WANTED_LENGTH = 3'd4;

    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST    = 8'd181;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND   = 8'd98;
    localparam logic [BYTE_W-1:0] RST_WANTED_CLASS  = 8'd1;
    localparam logic [BYTE_W-1:0] RST_WANTED_ID     = 8'd7;
    localparam logic [BYTE_W-1:0] RST_WANTED_LENGTH = 8'd92;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Byte positions within a frame, counted from the first sync byte; the checksum positions add the payload length.
    localparam int POS_SYNC2   = 1;
    localparam int POS_CLASS   = 2;
    localparam int POS_ID      = 3;
    localparam int POS_LEN_LO  = 4;
    localparam int POS_LEN_HI  = 5;
    localparam int POS_PAYLOAD = 6;
    localparam int POS_SUM_A   = 6;
    localparam int POS_SUM_B   = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
    } t_rx_item;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] message_class;
        logic [BYTE_W-1:0] message_id;
        logic [LEN_W-1:0]  payload_length;
        logic              checksum_ok;
        logic              record_match;
    } t_result;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] wanted_class;
        logic [BYTE_W-1:0] wanted_id;
        logic [BYTE_W-1:0] wanted_length;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/ubx_stream_if.sv
// ----------------------------------------------------------------------------
// ubx_stream_if
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface ubx_stream_if #(
    parameter type t_payload = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: sv/ubx_cfg_regs.sv
// ----------------------------------------------------------------------------
// ubx_cfg_regs
// Configuration registers written through a plain indexed write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_cfg_regs import ubx_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  t_cfg_idx          i_index,
    input  logic [BYTE_W-1:0] i_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                REG_SYNC_FIRST:    n_cfg.sync_first    = i_data;
                REG_SYNC_SECOND:   n_cfg.sync_second   = i_data;
                REG_WANTED_CLASS:  n_cfg.wanted_class  = i_data;
                REG_WANTED_ID:     n_cfg.wanted_id     = i_data;
                REG_WANTED_LENGTH: n_cfg.wanted_length = i_data;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= RST_SYNC_FIRST;
            r_cfg.sync_second   <= RST_SYNC_SECOND;
            r_cfg.wanted_class  <= RST_WANTED_CLASS;
            r_cfg.wanted_id     <= RST_WANTED_ID;
            r_cfg.wanted_length <= RST_WANTED_LENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/ubx_parse_core.sv
// ----------------------------------------------------------------------------
// ubx_parse_core
// Frame position counter, header capture and running Fletcher checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_parse_core import ubx_pkg::*; #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_adv,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_has_result,
    output t_result           o_result
);

    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CW-1:0] P_HUNT    = '0;
    localparam logic [CW-1:0] P_SYNC2   = CW'(POS_SYNC2);
    localparam logic [CW-1:0] P_CLASS   = CW'(POS_CLASS);
    localparam logic [CW-1:0] P_ID      = CW'(POS_ID);
    localparam logic [CW-1:0] P_LEN_LO  = CW'(POS_LEN_LO);
    localparam logic [CW-1:0] P_LEN_HI  = CW'(POS_LEN_HI);
    localparam logic [CW-1:0] P_PAYLOAD = CW'(POS_PAYLOAD);
    localparam logic [CW-1:0] P_LIMIT   = CW'(BUFFER_BYTES);

    logic [CW-1:0]     r_count,    n_count;
    logic [LEN_W-1:0]  r_len,      n_len;
    logic [BYTE_W-1:0] r_class,    n_class;
    logic [BYTE_W-1:0] r_id,       n_id;
    logic [BYTE_W-1:0] r_sum_a,    n_sum_a;
    logic [BYTE_W-1:0] r_sum_b,    n_sum_b;
    logic [BYTE_W-1:0] r_rx_sum_a, n_rx_sum_a;

    logic [CW-1:0]     w_next;
    logic [POS_W-1:0]  w_pos;
    logic [POS_W-1:0]  w_pay_end;
    logic [POS_W-1:0]  w_frame_end;
    logic              w_in_body;
    logic [BYTE_W-1:0] w_sum_a;
    logic              w_ok;
    logic              w_match;

    assign w_next      = r_count + CW'(1);
    assign w_pos       = POS_W'(r_count);
    assign w_pay_end   = POS_W'(r_len) + POS_W'(POS_SUM_A);
    assign w_frame_end = POS_W'(r_len) + POS_W'(POS_SUM_B);
    assign w_in_body   = (r_count >= P_PAYLOAD);
    assign w_sum_a     = r_sum_a + i_byte;
    assign w_ok        = (r_rx_sum_a == r_sum_a) && (i_byte == r_sum_b);
    assign w_match     = w_ok && (r_class == i_cfg.wanted_class)
                         && (r_id == i_cfg.wanted_id)
                         && (r_len == LEN_W'(i_cfg.wanted_length));

    always_comb begin
        n_count      = r_count;
        n_len        = r_len;
        n_class      = r_class;
        n_id         = r_id;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_rx_sum_a   = r_rx_sum_a;
        o_has_result = 1'b0;
        o_result                = '0;
        o_result.message_class  = r_class;
        o_result.message_id     = r_id;
        o_result.payload_length = r_len;

        priority if (r_count == P_HUNT) begin
            if (i_byte == i_cfg.sync_first) begin
                n_count = P_SYNC2;
            end
        end else if (r_count == P_SYNC2) begin
            if (i_byte != i_cfg.sync_second) begin
                n_count = P_HUNT;
            end else begin
                n_sum_a = '0;
                n_sum_b = '0;
                n_count = P_CLASS;
            end
        end else if (w_next >= P_LIMIT) begin
            n_count = P_HUNT;
        end else begin
            n_count = w_next;

            if (r_count == P_CLASS) begin
                n_class = i_byte;
            end
            if (r_count == P_ID) begin
                n_id = i_byte;
            end
            if (r_count == P_LEN_LO) begin
                n_len[BYTE_W-1:0] = i_byte;
            end
            if (r_count == P_LEN_HI) begin
                n_len[LEN_W-1:BYTE_W] = i_byte;
            end

            if (!w_in_body || (w_pos < w_pay_end)) begin
                n_sum_a = w_sum_a;
                n_sum_b = r_sum_b + w_sum_a;
            end else if (w_pos == w_pay_end) begin
                n_rx_sum_a = i_byte;
            end

            if (w_in_body && (w_pos == w_frame_end)) begin
                n_count               = P_HUNT;
                o_has_result          = 1'b1;
                o_result.result_kind  = KIND_END;
                o_result.checksum_ok  = w_ok;
                o_result.record_match = w_match;
            end else if (w_in_body && (w_pos < w_pay_end)) begin
                o_has_result          = 1'b1;
                o_result.result_kind  = KIND_PAYLOAD;
                o_result.payload_byte = i_byte;
                o_result.byte_index   = BYTE_W'(r_count - P_PAYLOAD);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= P_HUNT;
            r_len      <= '0;
            r_class    <= '0;
            r_id       <= '0;
            r_sum_a    <= '0;
            r_sum_b    <= '0;
            r_rx_sum_a <= '0;
        end else if (i_adv) begin
            r_count    <= n_count;
            r_len      <= n_len;
            r_class    <= n_class;
            r_id       <= n_id;
            r_sum_a    <= n_sum_a;
            r_sum_b    <= n_sum_b;
            r_rx_sum_a <= n_rx_sum_a;
        end
    end

endmodule

`default_nettype wire

FILE: sv/ubx_out_reg.sv
// ----------------------------------------------------------------------------
// ubx_out_reg
// Result register holding one word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_out_reg import ubx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_free
);

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: sv/ubx_frame_receiver.sv
// ----------------------------------------------------------------------------
// ubx_frame_receiver: sync hunt, header, payload and Fletcher-8 check per byte.
// Input register, then result register; one byte per cycle unless the output stalls.
// The single parse stage updating position and checksum per byte sets that rate.
// Synchronous active-low reset restores control and config registers, resumes sync hunt.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_receiver import ubx_pkg::*; #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ubx_stream_if.sink          i_rx,
    ubx_stream_if.source        o_res,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_index,
    input  logic [BYTE_W-1:0]   i_cfg_data
);

    t_cfg              w_cfg;
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              w_accept;
    logic              w_adv;
    logic              w_has_result;
    logic              w_out_free;
    t_result           w_result;
    t_rx_item          w_item;

    assign w_item     = i_rx.payload;
    assign w_adv      = r_in_valid && (!w_has_result || w_out_free);
    assign i_rx.ready = !r_in_valid || w_adv;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign n_in_valid = w_accept || (r_in_valid && !w_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= w_item.rx_byte;
        end
    end

    ubx_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    ubx_parse_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_adv        (w_adv),
        .i_byte       (r_in_byte),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    ubx_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv && w_has_result),
        .i_data  (w_result),
        .i_ready (o_res.ready),
        .o_valid (o_res.valid),
        .o_data  (o_res.payload),
        .o_free  (w_out_free)
    );

endmodule

`default_nettype wire

FILE: sv/ubx_chk.sv
// ----------------------------------------------------------------------------
// ubx_chk
// Port-level checker for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ubx_frame_receiver_assert.svh"

module ubx_chk import ubx_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_res_valid,
    input logic    i_res_ready,
    input t_result i_res
);

    `UBX_ASSERT_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !i_res_valid)
    `UBX_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n && i_res_valid && !i_res_ready, i_res_valid && $stable(i_res))
    `UBX_ASSERT_SAME(a_payload_no_verdict, i_clk, i_rst_n, i_res_valid && (i_res.result_kind == KIND_PAYLOAD), !i_res.checksum_ok && !i_res.record_match)
    `UBX_ASSERT_SAME(a_match_needs_sum, i_clk, i_rst_n, i_res_valid && i_res.record_match, i_res.checksum_ok && (i_res.result_kind == KIND_END))
    `UBX_ASSERT_SAME(a_end_fields_zero, i_clk, i_rst_n, i_res_valid && (i_res.result_kind == KIND_END), (i_res.payload_byte == '0) && (i_res.byte_index == '0))

endmodule

bind ubx_frame_receiver ubx_chk u_ubx_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res       (o_res.payload)
);

`default_nettype wire
